### rtl/core/mccm_pkg.sv
// shared types, constants and control store for the matrix chain cost unit
package mccm_pkg;

  localparam int unsigned MAX_MATRICES_DEF = 64;
  localparam int unsigned DIM_BITS_DEF     = 12;
  localparam int unsigned COST_W           = 48;
  localparam logic [COST_W-1:0] COST_MAX   = {COST_W{1'b1}};

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_MANY = 2'd2,
    ST_OVF  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SETUP,
    OP_PAIR,
    OP_GET_DI,
    OP_GET_DJ,
    OP_KREAD,
    OP_MUL1,
    OP_MUL2,
    OP_ACC,
    OP_WRITE,
    OP_LEN,
    OP_FINAL,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_LAST,
    C_BAD,
    C_ONE,
    C_K_MORE,
    C_I_MORE,
    C_LEN_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'd0,
    S_CHECK = 4'd1,
    S_ONE   = 4'd2,
    S_PAIR  = 4'd3,
    S_DI    = 4'd4,
    S_DJ    = 4'd5,
    S_KRD   = 4'd6,
    S_MUL1  = 4'd7,
    S_MUL2  = 4'd8,
    S_ACC   = 4'd9,
    S_WR    = 4'd10,
    S_LEN   = 4'd11,
    S_FINAL = 4'd12,
    S_EMIT  = 4'd13,
    S_DONE  = 4'd14
  } step_e;

  typedef struct packed {
    logic  in_rdy;
    op_e   op;
    cond_e cond;
    step_e target;
  } ctrl_t;

  typedef struct packed {
    logic acc_last;
    logic bad;
    logic one;
    logic k_more;
    logic i_more;
    logic len_more;
    logic out_busy;
  } flags_t;

  function automatic ctrl_t ucode(step_e s);
    ctrl_t w;
    w = '{in_rdy: 1'b0, op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
    case (s)
      S_IDLE:  w = '{in_rdy: 1'b1, op: OP_LOAD,   cond: C_NO_LAST,  target: S_IDLE};
      S_CHECK: w = '{in_rdy: 1'b0, op: OP_SETUP,  cond: C_BAD,      target: S_EMIT};
      S_ONE:   w = '{in_rdy: 1'b0, op: OP_NOP,    cond: C_ONE,      target: S_FINAL};
      S_PAIR:  w = '{in_rdy: 1'b0, op: OP_PAIR,   cond: C_NEXT,     target: S_IDLE};
      S_DI:    w = '{in_rdy: 1'b0, op: OP_GET_DI, cond: C_NEXT,     target: S_IDLE};
      S_DJ:    w = '{in_rdy: 1'b0, op: OP_GET_DJ, cond: C_NEXT,     target: S_IDLE};
      S_KRD:   w = '{in_rdy: 1'b0, op: OP_KREAD,  cond: C_NEXT,     target: S_IDLE};
      S_MUL1:  w = '{in_rdy: 1'b0, op: OP_MUL1,   cond: C_NEXT,     target: S_IDLE};
      S_MUL2:  w = '{in_rdy: 1'b0, op: OP_MUL2,   cond: C_NEXT,     target: S_IDLE};
      S_ACC:   w = '{in_rdy: 1'b0, op: OP_ACC,    cond: C_K_MORE,   target: S_KRD};
      S_WR:    w = '{in_rdy: 1'b0, op: OP_WRITE,  cond: C_I_MORE,   target: S_PAIR};
      S_LEN:   w = '{in_rdy: 1'b0, op: OP_LEN,    cond: C_LEN_MORE, target: S_PAIR};
      S_FINAL: w = '{in_rdy: 1'b0, op: OP_FINAL,  cond: C_NEXT,     target: S_IDLE};
      S_EMIT:  w = '{in_rdy: 1'b0, op: OP_EMIT,   cond: C_OUT_BUSY, target: S_EMIT};
      S_DONE:  w = '{in_rdy: 1'b0, op: OP_NOP,    cond: C_ALWAYS,   target: S_IDLE};
      default: w = '{in_rdy: 1'b0, op: OP_NOP,    cond: C_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/core/matrix_chain_min_cost_unit.sv
// top level of the matrix chain minimum cost unit
//
// input channel: one chain dimension per transfer, last_dim_i marks the end
// of a chain. dimensions load at one per cycle while the sequencer is idle;
// items past the store depth are dropped and flag the chain as too long.
// output channel: one transfer per chain with min_cost_o and status_o
// (ok, too few, too many, overflow).
// after the last dimension the microcode loops over split points, four
// steps per split (dimension and cost table reads, two multiplies,
// saturating min), using one dimension read port and two cost table read
// ports. the input is ready again in the cycle after the result is shown.
// bad chains skip the loop and go from the check step straight to emit.
// a finished result waits in the output register; new dimensions are still
// taken while it waits, and only the next result stalls until it leaves.
// reset returns the sequencer to idle, clears the dimension count and drops
// any pending result; the stores need no clearing.
module matrix_chain_min_cost_unit #(
  parameter int unsigned MAX_MATRICES = mccm_pkg::MAX_MATRICES_DEF,
  parameter int unsigned DIM_BITS     = mccm_pkg::DIM_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [DIM_BITS-1:0]         dimension_i,
  input  logic                        last_dim_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mccm_pkg::COST_W-1:0] min_cost_o,
  output logic [1:0]                  status_o
);

  mccm_pkg::ctrl_t  ctrl;
  mccm_pkg::flags_t flags;

  mccm_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  mccm_dp #(
    .MAX_MATRICES (MAX_MATRICES),
    .DIM_BITS     (DIM_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .flags_o     (flags),
    .in_valid_i  (in_valid_i),
    .dimension_i (dimension_i),
    .last_dim_i  (last_dim_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .min_cost_o  (min_cost_o),
    .status_o    (status_o)
  );

  assign in_ready_o = ctrl.in_rdy;

endmodule

### rtl/core/mccm_seq.sv
// microcode sequencer: step counter, control store lookup and conditional jumps
module mccm_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mccm_pkg::flags_t flags_i,
  output mccm_pkg::ctrl_t ctrl_o
);

  mccm_pkg::step_e upc_q, upc_d;
  logic            take;

  assign ctrl_o = mccm_pkg::ucode(upc_q);

  always_comb begin
    unique case (ctrl_o.cond)
      mccm_pkg::C_NEXT:     take = 1'b0;
      mccm_pkg::C_ALWAYS:   take = 1'b1;
      mccm_pkg::C_NO_LAST:  take = !flags_i.acc_last;
      mccm_pkg::C_BAD:      take = flags_i.bad;
      mccm_pkg::C_ONE:      take = flags_i.one;
      mccm_pkg::C_K_MORE:   take = flags_i.k_more;
      mccm_pkg::C_I_MORE:   take = flags_i.i_more;
      mccm_pkg::C_LEN_MORE: take = flags_i.len_more;
      mccm_pkg::C_OUT_BUSY: take = flags_i.out_busy;
      default:              take = 1'b1;
    endcase
  end

  always_comb begin
    if (take) begin
      upc_d = ctrl_o.target;
    end else begin
      upc_d = mccm_pkg::step_e'(4'(upc_q) + 4'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= mccm_pkg::S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

### rtl/core/mccm_dp.sv
// datapath: dimension store, cost table, multipliers, saturating min accumulate
module mccm_dp #(
  parameter int unsigned MAX_MATRICES = mccm_pkg::MAX_MATRICES_DEF,
  parameter int unsigned DIM_BITS     = mccm_pkg::DIM_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mccm_pkg::ctrl_t             ctrl_i,
  output mccm_pkg::flags_t            flags_o,
  input  logic                        in_valid_i,
  input  logic [DIM_BITS-1:0]         dimension_i,
  input  logic                        last_dim_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mccm_pkg::COST_W-1:0] min_cost_o,
  output logic [1:0]                  status_o
);

  localparam int unsigned STORE_DEPTH = MAX_MATRICES + 1;
  localparam int unsigned COUNT_FULL  = MAX_MATRICES + 2;
  localparam int unsigned CNT_W       = $clog2(MAX_MATRICES + 3);
  localparam int unsigned DA_W        = $clog2(MAX_MATRICES + 1);
  localparam int unsigned IDX_W       = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
  localparam int unsigned CA_W        = 2 * IDX_W;
  localparam int unsigned CW          = mccm_pkg::COST_W;

  function automatic logic [CW-1:0] sat_add(logic [CW-1:0] a, logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? mccm_pkg::COST_MAX : s[CW-1:0];
  endfunction

  logic [DIM_BITS-1:0] dim_mem [STORE_DEPTH];
  logic [CW-1:0]       cost_mem [2**CA_W];

  logic [CNT_W-1:0]      cnt_q;
  logic [DA_W-1:0]       m_q;
  logic [IDX_W-1:0]      len_q, i_q, j_q, k_q;
  logic [DIM_BITS-1:0]   di_q, dj_q, dim_rd_q;
  logic [2*DIM_BITS-1:0] p1_q;
  logic [CW-1:0]         prod_q, ca_rd_q, cb_rd_q, sab_q, best_q, res_cost_q;
  logic                  za_q, zb_q;
  logic [1:0]            res_status_q;
  logic                  out_valid_q;
  logic [CW-1:0]         min_cost_q;
  logic [1:0]            status_q;

  logic [DA_W-1:0]       dim_ra;
  logic                  dim_we;
  logic [CW-1:0]         ca, cb, cand;
  logic                  out_busy;

  assign out_busy = out_valid_q && !out_ready_i;

  always_comb begin
    flags_o.acc_last = in_valid_i && last_dim_i;
    flags_o.bad      = (cnt_q < CNT_W'(2)) || (cnt_q > CNT_W'(STORE_DEPTH));
    flags_o.one      = (m_q == DA_W'(1));
    flags_o.k_more   = ((IDX_W+1)'(k_q) + (IDX_W+1)'(1)) < (IDX_W+1)'(j_q);
    flags_o.i_more   = ((DA_W+1)'(i_q) + (DA_W+1)'(len_q) + (DA_W+1)'(1)) < (DA_W+1)'(m_q);
    flags_o.len_more = ((DA_W+1)'(len_q) + (DA_W+1)'(1)) < (DA_W+1)'(m_q);
    flags_o.out_busy = out_busy;
  end

  always_comb begin
    unique case (ctrl_i.op)
      mccm_pkg::OP_PAIR:   dim_ra = DA_W'(i_q);
      mccm_pkg::OP_GET_DI: dim_ra = DA_W'(j_q) + DA_W'(1);
      default:             dim_ra = DA_W'(k_q) + DA_W'(1);
    endcase
  end

  assign dim_we = (ctrl_i.op == mccm_pkg::OP_LOAD) && in_valid_i && ctrl_i.in_rdy
                  && (cnt_q < CNT_W'(STORE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (dim_we) begin
      dim_mem[cnt_q[DA_W-1:0]] <= dimension_i;
    end
    dim_rd_q <= dim_mem[dim_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == mccm_pkg::OP_WRITE) begin
      cost_mem[{i_q, j_q}] <= best_q;
    end
    ca_rd_q <= cost_mem[{i_q, k_q}];
    cb_rd_q <= cost_mem[{k_q + IDX_W'(1), j_q}];
  end

  assign ca   = za_q ? '0 : ca_rd_q;
  assign cb   = zb_q ? '0 : cb_rd_q;
  assign cand = sat_add(sab_q, prod_q);

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      mccm_pkg::OP_SETUP: begin
        m_q        <= DA_W'(cnt_q - CNT_W'(1));
        len_q      <= IDX_W'(1);
        i_q        <= '0;
        best_q     <= '0;
        res_cost_q <= '0;
        if (cnt_q < CNT_W'(2)) begin
          res_status_q <= mccm_pkg::ST_FEW;
        end else begin
          res_status_q <= mccm_pkg::ST_MANY;
        end
      end
      mccm_pkg::OP_PAIR: begin
        j_q    <= i_q + len_q;
        k_q    <= i_q;
        best_q <= mccm_pkg::COST_MAX;
      end
      mccm_pkg::OP_GET_DI: di_q <= dim_rd_q;
      mccm_pkg::OP_GET_DJ: dj_q <= dim_rd_q;
      mccm_pkg::OP_KREAD: begin
        za_q <= (k_q == i_q);
        zb_q <= ((k_q + IDX_W'(1)) == j_q);
      end
      mccm_pkg::OP_MUL1: p1_q <= di_q * dim_rd_q;
      mccm_pkg::OP_MUL2: begin
        prod_q <= CW'(p1_q * dj_q);
        sab_q  <= sat_add(ca, cb);
      end
      mccm_pkg::OP_ACC: begin
        if (cand < best_q) begin
          best_q <= cand;
        end
        k_q <= k_q + IDX_W'(1);
      end
      mccm_pkg::OP_WRITE: i_q <= i_q + IDX_W'(1);
      mccm_pkg::OP_LEN: begin
        len_q <= len_q + IDX_W'(1);
        i_q   <= '0;
      end
      mccm_pkg::OP_FINAL: begin
        res_cost_q <= best_q;
        if (best_q == mccm_pkg::COST_MAX) begin
          res_status_q <= mccm_pkg::ST_OVF;
        end else begin
          res_status_q <= mccm_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.op == mccm_pkg::OP_SETUP) begin
      cnt_q <= '0;
    end else if ((ctrl_i.op == mccm_pkg::OP_LOAD) && in_valid_i && ctrl_i.in_rdy) begin
      if (cnt_q < CNT_W'(STORE_DEPTH)) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else begin
        cnt_q <= CNT_W'(COUNT_FULL);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((ctrl_i.op == mccm_pkg::OP_EMIT) && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((ctrl_i.op == mccm_pkg::OP_EMIT) && !out_busy) begin
      min_cost_q <= res_cost_q;
      status_q   <= res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign min_cost_o  = min_cost_q;
  assign status_o    = status_q;

endmodule

### rtl/core/mccm_checker.sv
// port-level checker for the matrix chain minimum cost unit, with its bind
module mccm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [mccm_pkg::COST_W-1:0] min_cost_o,
  input logic [1:0]                  status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(min_cost_o) && $stable(status_o))
    else $error("result changed while stalled");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == mccm_pkg::ST_OVF) |-> (min_cost_o == mccm_pkg::COST_MAX))
    else $error("overflow status without saturated cost");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == mccm_pkg::ST_FEW) || (status_o == mccm_pkg::ST_MANY))
    |-> (min_cost_o == '0))
    else $error("error status with nonzero cost");

  a_ok_unsat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == mccm_pkg::ST_OK) |-> (min_cost_o != mccm_pkg::COST_MAX))
    else $error("ok status with saturated cost");

endmodule

bind matrix_chain_min_cost_unit mccm_checker u_mccm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .min_cost_o  (min_cost_o),
  .status_o    (status_o)
);

### verif/tb.sv
// self-checking testbench for the matrix chain minimum cost unit
`timescale 1ns / 1ps

module tb;
  import mccm_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_MATRICES_DEF + 1;
  localparam int unsigned COUNT_FULL  = MAX_MATRICES_DEF + 2;
  localparam int unsigned NUM_ITEMS   = 1600;
  localparam logic [DIM_BITS_DEF-1:0] DIM_TOP = {DIM_BITS_DEF{1'b1}};

  typedef enum int unsigned {
    MIX_WIDE,
    MIX_TOP,
    MIX_NARROW
  } dim_mix_e;

  typedef struct packed {
    logic [DIM_BITS_DEF-1:0] dim;
    logic                    last;
  } dim_item_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    status_e           status;
  } chain_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [DIM_BITS_DEF-1:0] dimension_i;
  logic                    last_dim_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [COST_W-1:0]       min_cost_o;
  logic [1:0]              status_o;

  dim_item_t         pending_items[$];
  chain_result_t     expected_results[$];
  logic [DIM_BITS_DEF-1:0] chain_dims [0:STORE_DEPTH-1];
  logic [COST_W-1:0] split_cost [0:MAX_MATRICES_DEF-1][0:MAX_MATRICES_DEF-1];
  int unsigned       chain_len;
  int unsigned       total_items;
  int unsigned       items_accepted;
  int unsigned       results_seen;
  int unsigned       failures;
  int unsigned       longest_chain;
  int unsigned       status_tally [0:3];
  logic              in_fire_q;
  logic              rx_hold;

  matrix_chain_min_cost_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .dimension_i (dimension_i),
    .last_dim_i  (last_dim_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .min_cost_o  (min_cost_o),
    .status_o    (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [COST_W-1:0] sat_sum(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

  function automatic logic [COST_W-1:0] chain_min_cost(int unsigned m);
    int unsigned span, i, j, k;
    logic [COST_W-1:0] best, cand, prod;
    for (i = 0; i < m; i++) split_cost[i][i] = '0;
    for (span = 1; span < m; span++) begin
      for (i = 0; i + span < m; i++) begin
        j = i + span;
        best = COST_MAX;
        for (k = i; k < j; k++) begin
          prod = COST_W'(chain_dims[i]) * COST_W'(chain_dims[k+1]) * COST_W'(chain_dims[j+1]);
          cand = sat_sum(sat_sum(split_cost[i][k], split_cost[k+1][j]), prod);
          if (cand < best) best = cand;
        end
        split_cost[i][j] = best;
      end
    end
    return split_cost[0][m-1];
  endfunction

  task automatic absorb_dim(dim_item_t item);
    chain_result_t r;
    if (chain_len < STORE_DEPTH) begin
      chain_dims[chain_len] = item.dim;
      chain_len++;
    end else begin
      chain_len = COUNT_FULL;
    end
    if (item.last) begin
      r.cost = '0;
      if (chain_len < 2) begin
        r.status = ST_FEW;
      end else if (chain_len > STORE_DEPTH) begin
        r.status = ST_MANY;
      end else begin
        r.cost   = chain_min_cost(chain_len - 1);
        r.status = (r.cost == COST_MAX) ? ST_OVF : ST_OK;
      end
      status_tally[r.status]++;
      chain_len = 0;
      expected_results.push_back(r);
    end
  endtask

  task automatic log_failure(string msg);
    failures++;
    if (failures <= 10) $display("mismatch: %s", msg);
  endtask

  function automatic logic [DIM_BITS_DEF-1:0] pick_dim(dim_mix_e mix);
    int unsigned r;
    r = $urandom_range(9);
    case (mix)
      MIX_TOP:    return DIM_TOP;
      MIX_NARROW: return DIM_BITS_DEF'($urandom_range(63));
      default: begin
        if (r == 0) return '0;
        if (r == 1) return DIM_TOP;
        return DIM_BITS_DEF'($urandom_range(DIM_TOP));
      end
    endcase
  endfunction

  task automatic push_dim(logic [DIM_BITS_DEF-1:0] dim, logic last);
    pending_items.push_back('{dim: dim, last: last});
  endtask

  task automatic queue_chain(int unsigned n_dims, dim_mix_e mix);
    for (int unsigned idx = 0; idx < n_dims; idx++) push_dim(pick_dim(mix), idx == n_dims - 1);
    if (n_dims > longest_chain) longest_chain = n_dims;
  endtask

  function automatic int unsigned idle_phase();
    if (items_accepted * 3 < total_items) return 0;
    if (items_accepted * 3 < total_items * 2) return 1;
    return 2;
  endfunction

  function automatic int unsigned send_idle_pct();
    case (idle_phase())
      0:       return 14;
      1:       return 48;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned recv_idle_pct();
    case (idle_phase())
      0:       return 48;
      1:       return 14;
      default: return 0;
    endcase
  endfunction

  always @(posedge clk_i) in_fire_q <= in_valid_i && in_ready_o;

  always @(negedge clk_i) begin
    dim_item_t nxt;
    if (rst_ni && (!in_valid_i || in_fire_q)) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
        nxt = pending_items.pop_front();
        in_valid_i  <= 1'b1;
        dimension_i <= nxt.dim;
        last_dim_i  <= nxt.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= !rx_hold && ($urandom_range(99) >= recv_idle_pct());
  end

  always @(posedge clk_i) begin
    chain_result_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          log_failure($sformatf("unexpected result cost=%0d status=%0d", min_cost_o, status_o));
        end else begin
          exp_r = expected_results.pop_front();
          if (min_cost_o !== exp_r.cost || status_o !== exp_r.status)
            log_failure($sformatf("result %0d: expected cost=%0d status=%0d, got cost=%0d status=%0d",
                                  results_seen, exp_r.cost, exp_r.status, min_cost_o, status_o));
        end
      end
      if (in_valid_i && in_ready_o) begin
        items_accepted++;
        absorb_dim('{dim: dimension_i, last: last_dim_i});
      end
    end
  end

  // long receiver stall so finished results back up into the input side
  initial begin
    rx_hold = 1'b0;
    while (results_seen < 12) @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (400) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #30_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned big_step;
    int unsigned r;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    dimension_i    = '0;
    last_dim_i     = 1'b0;
    out_ready_i    = 1'b0;
    chain_len      = 0;
    items_accepted = 0;
    results_seen   = 0;
    failures       = 0;
    longest_chain  = 0;
    big_step       = 0;
    for (int s = 0; s < 4; s++) status_tally[s] = 0;

    // directed: too short, single matrix, extreme and zero dims, a textbook chain
    push_dim(DIM_TOP, 1'b1);
    push_dim('0, 1'b1);
    push_dim('0, 1'b0);
    push_dim(DIM_TOP, 1'b1);
    push_dim(DIM_TOP, 1'b0);
    push_dim(DIM_TOP, 1'b0);
    push_dim(DIM_TOP, 1'b1);
    push_dim('0, 1'b0);
    push_dim('0, 1'b0);
    push_dim('0, 1'b0);
    push_dim('0, 1'b1);
    push_dim(12'd10, 1'b0);
    push_dim(12'd30, 1'b0);
    push_dim(12'd5, 1'b0);
    push_dim(12'd60, 1'b1);
    push_dim(12'd1, 1'b0);
    push_dim(DIM_TOP, 1'b0);
    push_dim(12'd1, 1'b0);
    push_dim(DIM_TOP, 1'b1);
    push_dim(12'hAAA, 1'b0);
    push_dim(12'h555, 1'b0);
    push_dim(12'hAAA, 1'b1);
    longest_chain = 4;

    // random chains, with a few full-store and over-long chains mixed in
    while (pending_items.size() < NUM_ITEMS) begin
      if (big_step == 0 && pending_items.size() > 300) begin
        queue_chain(STORE_DEPTH, MIX_TOP);
        big_step++;
      end else if (big_step == 1 && pending_items.size() > 700) begin
        queue_chain(STORE_DEPTH, MIX_WIDE);
        big_step++;
      end else if (big_step == 2 && pending_items.size() > 1000) begin
        queue_chain(STORE_DEPTH + 1, MIX_WIDE);
        big_step++;
      end else if (big_step == 3 && pending_items.size() > 1300) begin
        queue_chain($urandom_range(STORE_DEPTH + 2, 100), MIX_NARROW);
        big_step++;
      end else begin
        r = $urandom_range(99);
        if (r < 4)       queue_chain(1, MIX_WIDE);
        else if (r < 10) queue_chain($urandom_range(9, 16), r[0] ? MIX_WIDE : MIX_NARROW);
        else             queue_chain($urandom_range(2, 8), r[0] ? MIX_WIDE : MIX_NARROW);
      end
    end
    total_items = pending_items.size();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    if (expected_results.size() != 0)
      log_failure($sformatf("%0d results never arrived", expected_results.size()));
    $display("run: %0d dimensions in %0d chains, longest chain %0d dimensions",
             items_accepted, results_seen, longest_chain);
    $display("statuses: %0d ok, %0d too few, %0d too many, %0d overflow; %0d mismatches",
             status_tally[ST_OK], status_tally[ST_FEW], status_tally[ST_MANY],
             status_tally[ST_OVF], failures);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### matrix_chain_min_cost_unit.f
rtl/core/mccm_pkg.sv
rtl/core/mccm_seq.sv
rtl/core/mccm_dp.sv
rtl/core/matrix_chain_min_cost_unit.sv
rtl/core/mccm_checker.sv
verif/tb.sv
